/* rtl/sme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// Shared constants and types for the stack machine execute unit.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned PcWidthDef    = 16;
  localparam int unsigned DataW         = 32;

  typedef enum logic [3:0] {
    ActPush    = 4'd0,
    ActPop     = 4'd1,
    ActAdd     = 4'd2,
    ActSub     = 4'd3,
    ActMul     = 4'd4,
    ActDiv     = 4'd5,
    ActSqrt    = 4'd6,
    ActToReg   = 4'd7,
    ActFromReg = 4'd8,
    ActIn      = 4'd9,
    ActOut     = 4'd10,
    ActJump    = 4'd11
  } action_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StUnder   = 3'd1,
    StOver    = 3'd2,
    StDivZero = 3'd3,
    StNegRoot = 3'd4
  } status_e;

  // iterative unit control
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_cmd_t;

endpackage
`default_nettype wire

/* rtl/stack_machine_execute.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute
// Executes one decoded stack machine instruction per input word.
// ----------------------------------------------------------------------------
// One instruction at a time. The operand stack is a synchronous RAM with a
// registered read; an instruction loads top and next in S_RD1 and S_RD2,
// computes and writes back in S_EXEC, then moves on to S_DONE. Divide and
// square root go through a shared bit-serial unit in S_ITER. The result sits
// in an output register, and the next word is taken once it has been handed
// over.
module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDef,
  parameter int unsigned PC_WIDTH    = sme_pkg::PcWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         action_i,
  input  wire logic [7:0]         immediate_i,
  input  wire logic [2:0]         reg_select_i,
  input  wire logic [15:0]        jump_target_i,
  input  wire logic signed [31:0] in_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_value_o,
  output logic                    out_valid_flag_o,
  output logic [15:0]             next_pc_o,
  output logic [2:0]              status_o
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = AW + 1;
  localparam logic [SPW-1:0] Depth = SPW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_DONE
  } state_e;

  state_e state_q;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] rdata_q;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  logic [SPW-1:0] sp_q;
  logic [PC_WIDTH-1:0] pc_q;
  logic [31:0] regs_q [4];
  logic [31:0] top_q, next_q;

  logic [3:0]  act_q;
  logic [7:0]  imm_q;
  logic [2:0]  rsel_q;
  logic [15:0] tgt_q;
  logic [31:0] inv_q;

  logic        ov_q;
  logic [31:0] outv_q;
  logic        outf_q;
  logic [2:0]  st_q;

  sme_pkg::iter_cmd_t icmd;
  logic        idone;
  logic [31:0] ires;

  sme_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (icmd),
    .a_i    (top_q),
    .b_i    (next_q),
    .done_o (idone),
    .res_o  (ires)
  );

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;

  // read address: top in S_IDLE->RD1, next in RD1
  always_comb begin
    raddr = '0;
    if (state_q == S_RD1) raddr = AW'(sp_q - SPW'(2));
    else                  raddr = AW'(sp_q - SPW'(1));
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= stack_mem[raddr];
    if (we) stack_mem[waddr] <= wdata;
  end

  logic [31:0] arith;
  logic [31:0] greg;
  logic        sp_ge1, sp_ge2, full;

  assign sp_ge1 = sp_q != '0;
  assign sp_ge2 = sp_q > SPW'(1);
  assign full   = sp_q >= Depth;
  assign greg   = regs_q[rsel_q[1:0]];

  always_comb begin
    case (act_q)
      sme_pkg::ActAdd: arith = top_q + next_q;
      sme_pkg::ActSub: arith = top_q - next_q;
      default:         arith = top_q * next_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(sp_q);
    wdata = arith;
    icmd  = '0;
    if (state_q == S_EXEC) begin
      case (act_q)
        sme_pkg::ActPush: begin
          we = !full; wdata = {24'd0, imm_q};
        end
        sme_pkg::ActIn: begin
          we = !full; wdata = inv_q;
        end
        sme_pkg::ActFromReg: begin
          we = !full && !rsel_q[2]; wdata = greg;
        end
        sme_pkg::ActAdd, sme_pkg::ActSub, sme_pkg::ActMul: begin
          we = sp_ge2; waddr = AW'(sp_q - SPW'(2));
        end
        sme_pkg::ActDiv: begin
          icmd.start = sp_ge2 && (next_q != '0);
        end
        sme_pkg::ActSqrt: begin
          icmd.start = sp_ge1 && !top_q[31]; icmd.is_sqrt = 1'b1;
        end
        default: ;
      endcase
    end else if (state_q == S_ITER && idone) begin
      we    = 1'b1;
      wdata = ires;
      waddr = (act_q == sme_pkg::ActDiv) ? AW'(sp_q - SPW'(2)) : AW'(sp_q - SPW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1) top_q  <= rdata_q;
    if (state_q == S_RD2) next_q <= rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      imm_q  <= immediate_i;
      rsel_q <= reg_select_i;
      tgt_q  <= jump_target_i;
      inv_q  <= in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      pc_q    <= '0;
      regs_q  <= '{default: '0};
      ov_q    <= 1'b0;
      outv_q  <= '0;
      outf_q  <= 1'b0;
      st_q    <= sme_pkg::StOk;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_EXEC;
        S_EXEC: begin
          outv_q  <= '0;
          outf_q  <= 1'b0;
          st_q    <= sme_pkg::StOk;
          state_q <= S_DONE;
          pc_q    <= pc_q + PC_WIDTH'(1);
          case (act_q)
            sme_pkg::ActPush, sme_pkg::ActIn: begin
              if (act_q == sme_pkg::ActPush) pc_q <= pc_q + PC_WIDTH'(2);
              if (full) st_q <= sme_pkg::StOver;
              else      sp_q <= sp_q + SPW'(1);
            end
            sme_pkg::ActFromReg: begin
              pc_q <= pc_q + PC_WIDTH'(2);
              if (!rsel_q[2]) begin
                if (full) st_q <= sme_pkg::StOver;
                else      sp_q <= sp_q + SPW'(1);
              end
            end
            sme_pkg::ActPop: begin
              if (!sp_ge1) st_q <= sme_pkg::StUnder;
              else         sp_q <= sp_q - SPW'(1);
            end
            sme_pkg::ActToReg: begin
              pc_q <= pc_q + PC_WIDTH'(2);
              if (!sp_ge1) st_q <= sme_pkg::StUnder;
              else begin
                sp_q <= sp_q - SPW'(1);
                if (!rsel_q[2]) regs_q[rsel_q[1:0]] <= top_q;
              end
            end
            sme_pkg::ActOut: begin
              if (!sp_ge1) st_q <= sme_pkg::StUnder;
              else begin
                sp_q   <= sp_q - SPW'(1);
                outv_q <= top_q;
                outf_q <= 1'b1;
              end
            end
            sme_pkg::ActAdd, sme_pkg::ActSub, sme_pkg::ActMul: begin
              if (!sp_ge2) st_q <= sme_pkg::StUnder;
              else         sp_q <= sp_q - SPW'(1);
            end
            sme_pkg::ActDiv: begin
              if (!sp_ge2)              st_q <= sme_pkg::StUnder;
              else if (next_q == '0)    st_q <= sme_pkg::StDivZero;
              else                      state_q <= S_ITER;
            end
            sme_pkg::ActSqrt: begin
              if (!sp_ge1)       st_q <= sme_pkg::StUnder;
              else if (top_q[31]) st_q <= sme_pkg::StNegRoot;
              else               state_q <= S_ITER;
            end
            sme_pkg::ActJump: pc_q <= PC_WIDTH'(tgt_q);
            default: ;
          endcase
        end
        S_ITER: if (idone) begin
          if (act_q == sme_pkg::ActDiv) sp_q <= sp_q - SPW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          ov_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = ov_q;
  assign out_value_o      = outv_q;
  assign out_valid_flag_o = outf_q;
  assign next_pc_o        = 16'(pc_q);
  assign status_o         = st_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= Depth) else $error("stack pointer out of range");
  a_iter_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idone |-> (state_q == S_ITER)) else $error("stray iterative result");
`endif

endmodule
`default_nettype wire

/* rtl/sme_iter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_iter
// Iterative signed divide (top / next, truncating) and floor square root.
// One quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module sme_iter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sme_pkg::iter_cmd_t cmd_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  output logic                   done_o,
  output logic [31:0]            res_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic        neg_q, neg_d;
  logic [31:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic        done_q, done_d;

  logic [31:0] abs_a, abs_b;
  logic [33:0] trial, sub;
  logic [33:0] sq_trial;

  assign abs_a = a_i[31] ? (32'd0 - a_i) : a_i;
  assign abs_b = b_i[31] ? (32'd0 - b_i) : b_i;

  // divide: rem holds partial remainder, quo shifts out dividend bits and shifts in quotient bits
  assign trial    = {rem_q[32:0], quo_q[31]};
  assign sub      = trial - {2'b00, div_q};
  // sqrt: rem is remainder, div holds radicand, quo holds root
  assign sq_trial = {rem_q[31:0], div_q[31:30]} - {quo_q[31:0], 2'b01};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      sqrt_d = cmd_i.is_sqrt;
      rem_d  = '0;
      if (cmd_i.is_sqrt) begin
        cnt_d = 6'd16;
        quo_d = '0;
        div_d = a_i;
        neg_d = 1'b0;
      end else begin
        cnt_d = 6'd32;
        quo_d = abs_a;
        div_d = abs_b;
        neg_d = a_i[31] ^ b_i[31];
      end
    end else if (busy_q) begin
      if (sqrt_q) begin
        div_d = {div_q[29:0], 2'b00};
        if (!sq_trial[33]) begin
          rem_d = sq_trial;
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], div_q[31:30]};
          quo_d = {quo_q[30:0], 1'b0};
        end
      end else begin
        if (!sub[33]) begin
          rem_d = sub;
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule
`default_nettype wire
